>>> hw/rtl/rlad_pkg.sv
// Shared types and constants of the run-length alpha decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rlad_pkg;

   localparam int MaxResults = 3;
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int IdxWidth   = $clog2(MaxResults);

   localparam logic [31:0] TotalPixelsReset = 32'd1;

   localparam logic [7:0] RunMask     = 8'h7f;
   localparam logic [3:0] NibbleMask  = 4'hf;

   localparam logic [2:0] STATUS_RUN       = 3'd0;
   localparam logic [2:0] STATUS_COMPLETE  = 3'd1;
   localparam logic [2:0] STATUS_OVERFLOW  = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd3;
   localparam logic [2:0] STATUS_TOO_FEW   = 3'd4;
   localparam logic [2:0] STATUS_EXCESS    = 3'd5;

   typedef enum logic [1:0] {
      PHASE_TOKEN   = 2'd0,
      PHASE_LITERAL = 2'd1,
      PHASE_DISCARD = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] run_length;
      logic [2:0] status;
      logic       last_result;
   } rsp_type;

   typedef struct packed {
      rsp_type [MaxResults-1:0] item;
      logic [CountWidth-1:0]    count;
   } bundle_type;

endpackage

>>> hw/rtl/rlad_core.sv
// Token decode, pixel accounting and error detection for one payload beat.
// Depends on rlad_pkg; emits a bundle of up to three results per beat.
`timescale 1ns / 1ps

module rlad_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  rlad_pkg::req_type   req,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   output rlad_pkg::bundle_type bundle
);
   import rlad_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  left_ff, left_in;
   logic [31:0] done_ff, done_in;
   logic [31:0] total_ff;

   logic [7:0]            run_len;
   logic [32:0]           run_end;
   logic                  two_px;
   logic [1:0]            lit_step;
   logic [CountWidth-1:0] n;

   function automatic rsp_type make_rsp(logic [7:0] a, logic [7:0] len, logic [2:0] st);
      rsp_type r;
      r.alpha       = a;
      r.run_length  = len;
      r.status      = st;
      r.last_result = 1'b0;
      return r;
   endfunction

   function automatic logic [7:0] scale17(logic [3:0] nib);
      return {nib, nib};
   endfunction

   always_comb begin
      bundle   = '0;
      n        = '0;
      phase_in = phase_ff;
      left_in  = left_ff;
      done_in  = done_ff;
      two_px   = 1'b0;
      lit_step = 2'd0;
      run_len  = (req.data_byte & RunMask) + 8'd1;
      run_end  = {1'b0, done_ff} + {25'd0, run_len};

      unique case (phase_ff)
         PHASE_TOKEN: begin
            if (done_ff >= total_ff) begin
               bundle.item[IdxWidth'(n)] = make_rsp(8'd0, 8'd0, STATUS_EXCESS);
               n = n + CountWidth'(1);
               phase_in = PHASE_DISCARD;
            end else if (run_end > {1'b0, total_ff}) begin
               bundle.item[IdxWidth'(n)] = make_rsp(8'd0, 8'd0, STATUS_OVERFLOW);
               n = n + CountWidth'(1);
               phase_in = PHASE_DISCARD;
            end else if (!req.data_byte[7]) begin
               bundle.item[IdxWidth'(n)] = make_rsp(8'd0, run_len, STATUS_RUN);
               n = n + CountWidth'(1);
               done_in = run_end[31:0];
            end else begin
               phase_in = PHASE_LITERAL;
               left_in  = run_len;
            end
         end
         PHASE_LITERAL: begin
            two_px = left_ff > 8'd1;
            bundle.item[IdxWidth'(n)] =
               make_rsp(scale17(req.data_byte[7:4] & NibbleMask), 8'd1, STATUS_RUN);
            n = n + CountWidth'(1);
            if (two_px) begin
               bundle.item[IdxWidth'(n)] =
                  make_rsp(scale17(req.data_byte[3:0] & NibbleMask), 8'd1, STATUS_RUN);
               n = n + CountWidth'(1);
            end
            lit_step = two_px ? 2'd2 : 2'd1;
            done_in  = done_ff + {30'd0, lit_step};
            left_in  = left_ff - {6'd0, lit_step};
            if (left_in == 8'd0) begin
               phase_in = PHASE_TOKEN;
            end
         end
         default: begin
         end
      endcase

      if (req.final_byte) begin
         if (phase_in == PHASE_LITERAL) begin
            bundle.item[IdxWidth'(n)] = make_rsp(8'd0, 8'd0, STATUS_TRUNCATED);
            n = n + CountWidth'(1);
         end else if (phase_in == PHASE_TOKEN) begin
            bundle.item[IdxWidth'(n)] = make_rsp(8'd0, 8'd0,
               (done_in == total_ff) ? STATUS_COMPLETE : STATUS_TOO_FEW);
            n = n + CountWidth'(1);
         end
         phase_in = PHASE_TOKEN;
         left_in  = 8'd0;
         done_in  = 32'd0;
      end

      if (n != '0) begin
         bundle.item[IdxWidth'(n - CountWidth'(1))].last_result = 1'b1;
      end
      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_TOKEN;
         left_ff  <= 8'd0;
         done_ff  <= 32'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TotalPixelsReset;
      end else if (csr_wr_en) begin
         total_ff <= csr_wr_data;
      end
   end

endmodule

>>> hw/rtl/rlad_serializer.sv
// Result buffer: holds decoded bundles and sends their results one beat at a time.
// Depends on rlad_pkg; a skid bundle takes one more input bundle while the output stalls.
`timescale 1ns / 1ps

module rlad_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rlad_pkg::bundle_type bundle,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rlad_pkg::rsp_type    rsp_data
);
   import rlad_pkg::*;

   bundle_type          cur_ff, cur_in;
   bundle_type          skid_ff, skid_in;
   logic                cur_valid_ff, cur_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;

   logic pop;
   logic finishing;
   logic cur_free;

   assign rsp_valid = cur_valid_ff;
   assign rsp_data  = cur_ff.item[idx_ff];
   assign full      = skid_valid_ff;

   always_comb begin
      pop       = cur_valid_ff && !rsp_stall;
      finishing = pop && (CountWidth'(idx_ff) == cur_ff.count - CountWidth'(1));
      cur_free  = !cur_valid_ff || finishing;

      cur_in        = cur_ff;
      skid_in       = skid_ff;
      cur_valid_in  = cur_valid_ff;
      skid_valid_in = skid_valid_ff;
      idx_in        = idx_ff;

      if (cur_free) begin
         idx_in = '0;
         if (skid_valid_ff) begin
            cur_in        = skid_ff;
            cur_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            cur_in       = bundle;
            cur_valid_in = 1'b1;
         end else begin
            cur_valid_in = 1'b0;
         end
      end else begin
         if (pop) begin
            idx_in = idx_ff + IdxWidth'(1);
         end
         if (push) begin
            skid_in       = bundle;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         cur_valid_ff  <= cur_valid_in;
         skid_valid_ff <= skid_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      skid_ff <= skid_in;
   end

endmodule

>>> hw/rtl/rle_alpha_atlas_decoder.sv
// Run-length alpha decoder top level: byte input, result output, pixel-count register.
// Depends on rlad_pkg, rlad_core and rlad_serializer.
`timescale 1ns / 1ps

// Takes one payload beat per cycle while req_stall is low, turning it into
// zero to three results (pixel runs and status reports). While rsp_stall
// is low the result port sends one result per cycle, so a byte's results
// leave one after another and bytes with one result or none sustain one
// byte per cycle. Decoding finishes in the cycle a byte is accepted; its
// results appear on the next cycle at the earliest. A two-bundle result
// buffer lets a new byte enter while earlier results wait; req_stall comes
// straight from a register. total_pixels resets to 1; the user must write
// it through csr_wr_en/csr_wr_data only while idle, unchecked by the block.
module rle_alpha_atlas_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rlad_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rlad_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);
   import rlad_pkg::*;

   bundle_type bundle;
   logic       accept;
   logic       full;
   logic       push;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign push      = accept && (bundle.count != '0);

   rlad_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .bundle      (bundle)
   );

   rlad_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .bundle    (bundle),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> test/rlad_decode_checker.sv
// Result checker for the run-length alpha decoder: tracks total_pixels writes,
// predicts the results of every accepted byte and compares them in order.
// Depends on rlad_pkg.
`timescale 1ns / 1ps

module rlad_decode_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rlad_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rlad_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   output int                fail_count,
   output int                outstanding
);
   import rlad_pkg::*;

   localparam logic [7:0] LiteralFlag = 8'h80;

   rsp_type     due_runs[$];
   logic [31:0] total_pixels;
   phase_type   phase;
   logic [7:0]  literal_left;
   logic [31:0] pixels_done;
   int          errors = 0;

   function automatic rsp_type make_result(logic [7:0] alpha, logic [7:0] len, logic [2:0] st);
      rsp_type r;
      r.alpha       = alpha;
      r.run_length  = len;
      r.status      = st;
      r.last_result = 1'b0;
      return r;
   endfunction

   function automatic logic [7:0] scale_nibble(logic [3:0] nib);
      return 8'(17 * nib);
   endfunction

   function automatic void restart_image();
      phase        = PHASE_TOKEN;
      literal_left = '0;
      pixels_done  = '0;
   endfunction

   function automatic void decode_beat(req_type beat);
      rsp_type     found[MaxResults];
      int          n;
      logic [7:0]  len;
      logic [31:0] room;
      n = 0;
      if (phase == PHASE_TOKEN) begin
         len  = (beat.data_byte & RunMask) + 8'd1;
         room = (pixels_done < total_pixels) ? total_pixels - pixels_done : 32'd0;
         if (room == 0) begin
            found[n] = make_result(8'd0, 8'd0, STATUS_EXCESS);
            n++;
            phase = PHASE_DISCARD;
         end else if (32'(len) > room) begin
            found[n] = make_result(8'd0, 8'd0, STATUS_OVERFLOW);
            n++;
            phase = PHASE_DISCARD;
         end else if ((beat.data_byte & LiteralFlag) == 0) begin
            found[n] = make_result(8'd0, len, STATUS_RUN);
            n++;
            pixels_done += 32'(len);
         end else begin
            phase        = PHASE_LITERAL;
            literal_left = len;
         end
      end else if (phase == PHASE_LITERAL) begin
         found[n] = make_result(scale_nibble(beat.data_byte[7:4]), 8'd1, STATUS_RUN);
         n++;
         pixels_done  += 32'd1;
         literal_left -= 8'd1;
         if (literal_left != 0) begin
            found[n] = make_result(scale_nibble(beat.data_byte[3:0]), 8'd1, STATUS_RUN);
            n++;
            pixels_done  += 32'd1;
            literal_left -= 8'd1;
         end
         if (literal_left == 0) phase = PHASE_TOKEN;
      end
      if (beat.final_byte) begin
         if (phase == PHASE_LITERAL) begin
            found[n] = make_result(8'd0, 8'd0, STATUS_TRUNCATED);
            n++;
         end else if (phase == PHASE_TOKEN) begin
            found[n] = make_result(8'd0, 8'd0,
                                   pixels_done == total_pixels ? STATUS_COMPLETE
                                                               : STATUS_TOO_FEW);
            n++;
         end
         restart_image();
      end
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) found[i].last_result = 1'b1;
         due_runs = {due_runs, found[i]};
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         total_pixels = TotalPixelsReset;
         restart_image();
         due_runs.delete();
      end else begin
         if (csr_wr_en) total_pixels = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (due_runs.size() == 0) begin
               $error("result with none expected: alpha %0d run_length %0d status %0d",
                      rsp_data.alpha, rsp_data.run_length, rsp_data.status);
               errors++;
            end else begin
               want = due_runs.pop_front();
               check_field("alpha", want.alpha, rsp_data.alpha);
               check_field("run_length", want.run_length, rsp_data.run_length);
               check_field("status", 8'(want.status), 8'(rsp_data.status));
               check_field("last_result", 8'(want.last_result), 8'(rsp_data.last_result));
            end
         end
         if (req_valid && !req_stall) decode_beat(req_data);
      end
      fail_count  <= errors;
      outstanding <= due_runs.size();
   end

endmodule

>>> test/rle_alpha_atlas_decoder_test.sv
// Testbench top for rle_alpha_atlas_decoder: clock, reset, byte stimulus,
// random receiver stalls and the verdict. Depends on rlad_pkg and rlad_decode_checker.
`timescale 1ns / 1ps

module rle_alpha_atlas_decoder_test;
   import rlad_pkg::*;

   localparam logic [7:0]  LiteralFlag    = 8'h80;
   localparam logic [31:0] TotalPixelsMax = 32'hFFFE_0001;
   localparam int          ByteBudget     = 200;
   localparam int          PressureCycles = 80;
   localparam int          PressureBeats  = 6;
   localparam int          DrainCycles    = 16;
   localparam int          WatchdogLimit  = 2000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;
   bit          pressure_go = 1'b0;
   bit          pressure_on = 1'b0;
   int          fail_count;
   int          outstanding;
   int          bytes_sent  = 0;
   int          idle_cycles = 0;

   always #1 clock = ~clock;

   rle_alpha_atlas_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rlad_decode_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_beat(input logic [7:0] data, input logic fin);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data.data_byte   <= data;
      req_data.final_byte  <= fin;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_total(input logic [31:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_image(input logic [31:0] total);
      logic [7:0] image[$];
      int         left;
      int         len;
      int         kind;
      int         keep;
      bit         last;
      if (total > 4096 || $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 12)) image = {image, 8'($urandom)};
         kind = 3;
      end else begin
         left = total;
         while (left > 0) begin
            if ($urandom_range(0, 3) != 0) len = $urandom_range(1, left < 8 ? left : 8);
            else len = $urandom_range(1, left < 128 ? left : 128);
            if ($urandom_range(0, 1)) begin
               image = {image, LiteralFlag | 8'(len - 1)};
               repeat ((len + 1) / 2) image = {image, 8'($urandom)};
            end else begin
               image = {image, 8'(len - 1)};
            end
            left -= len;
         end
         kind = $urandom_range(0, 7);
         if (kind == 0) begin
            keep = $urandom_range(1, image.size());
            while (image.size() > keep) image.delete(image.size() - 1);
         end else if (kind == 1) begin
            image = {image, 8'($urandom)};
         end else if (kind == 2) begin
            image.push_front(8'($urandom_range(0, 255)) | 8'h7f);
         end
      end
      foreach (image[i]) begin
         last = i == image.size() - 1 || bytes_sent >= ByteBudget - 1;
         send_beat(image[i], last || (kind == 3 && $urandom_range(0, 15) == 0));
         if (last) break;
      end
   endtask

   // receiver: random hold-offs, one long hold on request
   initial begin : receiver
      int  n;
      bit  pressured;
      pressured = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (pressure_go && !pressured) begin
            pressured = 1'b1;
            rsp_stall   <= 1'b1;
            pressure_on <= 1'b1;
            repeat (PressureCycles) @(posedge clock);
         end
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [31:0] total;
      int          r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single pixel image at the reset total
      send_beat(8'h00, 1'b1);
      set_total(32'd10);
      send_beat(8'h83, 1'b0);
      send_beat(8'hF0, 1'b0);
      send_beat(8'h0F, 1'b0);
      send_beat(8'h05, 1'b1);
      // odd literal, then overflow and discard up to the final byte
      send_beat(8'h82, 1'b0);
      send_beat(8'hAB, 1'b0);
      send_beat(8'hCD, 1'b0);
      send_beat(8'h7F, 1'b0);
      send_beat(8'h12, 1'b0);
      send_beat(8'hFF, 1'b1);
      // truncated literal, too few pixels, excess payload
      send_beat(8'h84, 1'b0);
      send_beat(8'h5A, 1'b1);
      send_beat(8'h01, 1'b1);
      send_beat(8'h09, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h33, 1'b1);
      send_beat(8'h7F, 1'b1);
      send_beat(8'h80, 1'b1);
      // shrink the total mid-image
      send_beat(8'h04, 1'b0);
      set_total(32'd3);
      send_beat(8'h00, 1'b1);
      set_total(32'd1);
      send_beat(8'h80, 1'b0);
      send_beat(8'h9C, 1'b1);
      set_total(TotalPixelsMax);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h3C, 1'b1);
      send_beat(8'h7F, 1'b1);

      // long receiver hold while beats keep coming, so the block fills up
      set_total(TotalPixelsMax);
      pressure_go <= 1'b1;
      while (!pressure_on) @(posedge clock);
      req_valid           <= 1'b1;
      req_data.data_byte  <= 8'h00;
      req_data.final_byte <= 1'b0;
      repeat (PressureBeats) begin
         do @(posedge clock); while (req_stall);
         bytes_sent++;
      end
      send_beat(8'h00, 1'b1);

      while (bytes_sent < ByteBudget) begin
         r = $urandom_range(0, 99);
         if (r < 80) total = $urandom_range(1, 40);
         else if (r < 92) total = $urandom_range(100, 600);
         else if (r < 96) total = 32'd1;
         else total = TotalPixelsMax;
         set_total(total);
         repeat ($urandom_range(2, 4)) begin
            if (bytes_sent < ByteBudget) send_image(total);
         end
      end

      wait_idle();
      if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/rlad_pkg.sv
hw/rtl/rlad_core.sv
hw/rtl/rlad_serializer.sv
hw/rtl/rle_alpha_atlas_decoder.sv
test/rlad_decode_checker.sv
test/rle_alpha_atlas_decoder_test.sv
